// File: rtl/core/wss_pkg.sv
package wss_pkg;

	// Sizing
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int AMT_W     = 8;
	localparam int BIT_W     = $clog2(AMT_W);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Operation codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_PEEK = 3'd2;
	localparam logic [2:0] OP_DUP  = 3'd3;
	localparam logic [2:0] OP_SWAP = 3'd4;
	localparam logic [2:0] OP_ROT  = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FEW   = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]       op;
		logic [31:0]      value;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [31:0] top_word;
		logic [4:0]  count;
		logic [1:0]  status;
	} rsp_t;

endpackage

// File: rtl/core/word_stack_with_dup_swap_rotate.sv
// LIFO stack of DEPTH words with push, pop, peek, duplicate, swap and rotate.
// Push, pop, peek, duplicate, swap, rotate with fewer than two entries and the
// unused op codes are answered through the response register, and a new request is taken every cycle
// while the response slot is free or being drained. For a rotate over n >= 2
// entries the distance is first reduced modulo n by a bit-serial remainder
// unit (one amount bit per cycle, then a result pulse), then the entries are
// copied one per cycle from the read port of the active bank, or from the top
// register, into the other bank, which then becomes active; the last one goes
// to the top register. No request is taken during a rotate. The top entry is
// held in a register; the rest lives in two single-port-write memory banks.
module word_stack_with_dup_swap_rotate (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  wss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output wss_pkg::rsp_t rsp
);
	import wss_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_MOD, S_COPY, S_DRAIN} state_t;

	state_t state_q;
	cnt_t   fill_q;
	word_t  tos_q;
	logic   sel_q;
	logic   fwd_q;
	word_t  fwd_data_q;
	cnt_t   idx_q;
	cnt_t   src_q;
	logic   v_s1;
	cnt_t   dst_s1;
	logic   src_tos_s1;

	word_t rd_a, rd_b, rd_sel, nos;
	logic  accept;
	cnt_t  fill_d;
	word_t tos_d;
	logic [1:0] status_d;
	logic  wr_act;
	addr_t wr_addr;
	word_t wr_data;
	logic  rot_go;
	logic  rot_last;
	logic  rot_we;
	word_t rot_src;
	addr_t rd_addr;
	logic  we_a, we_b;
	addr_t waddr_a, waddr_b;
	word_t wdata_a, wdata_b;
	logic  mod_done;
	cnt_t  mod_rem;
	word_t word_in;
	rsp_t  rsp_d;
	cnt_t  last_idx;

	assign word_in  = WORD_BITS'(req.value);
	assign last_idx = fill_q - 1'b1;
	assign rd_sel   = sel_q ? rd_b : rd_a;
	assign nos      = fwd_q ? fwd_data_q : rd_sel;
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid || rsp_ready);
	assign accept    = req_valid && req_ready;

	// Rotate copy stage: data arrives in the cycle after its read
	assign rot_src  = src_tos_s1 ? tos_q : rd_sel;
	assign rot_last = v_s1 && (dst_s1 == last_idx);
	assign rot_we   = v_s1 && !rot_last;

	// Operation decode and next state
	always_comb begin
		fill_d   = fill_q;
		tos_d    = tos_q;
		status_d = ST_OK;
		wr_act   = 1'b0;
		wr_addr  = ADDR_W'(fill_q - 1'b1);
		wr_data  = tos_q;
		rot_go   = 1'b0;
		if (rot_last) begin
			tos_d = rot_src;
		end
		if (accept) begin
			unique case (req.op)
				OP_PUSH: begin
					if (fill_q == CNT_W'(DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						wr_act = (fill_q != '0);
						tos_d  = word_in;
						fill_d = fill_q + 1'b1;
					end
				end
				OP_POP: begin
					if (fill_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						tos_d  = nos;
						fill_d = fill_q - 1'b1;
					end
				end
				OP_PEEK: begin
					if (fill_q == '0) begin
						status_d = ST_EMPTY;
					end
				end
				OP_DUP: begin
					if (fill_q == '0) begin
						status_d = ST_EMPTY;
					end else if (fill_q == CNT_W'(DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						wr_act = 1'b1;
						fill_d = fill_q + 1'b1;
					end
				end
				OP_SWAP: begin
					if (fill_q < CNT_W'(2)) begin
						status_d = ST_FEW;
					end else begin
						wr_act  = 1'b1;
						wr_addr = ADDR_W'(fill_q - CNT_W'(2));
						tos_d   = nos;
					end
				end
				OP_ROT: begin
					rot_go = (fill_q >= CNT_W'(2));
				end
				default: begin
				end
			endcase
		end
	end

	// Read address: copy sweep source, otherwise the entry under the new top
	always_comb begin
		if (state_q == S_COPY) begin
			rd_addr = ADDR_W'(src_q);
		end else begin
			rd_addr = ADDR_W'(fill_d - CNT_W'(2));
		end
	end

	// Bank steering: normal writes to the active bank, copy writes to the other
	always_comb begin
		we_a    = sel_q ? rot_we : wr_act;
		we_b    = sel_q ? wr_act : rot_we;
		waddr_a = sel_q ? ADDR_W'(dst_s1) : wr_addr;
		waddr_b = sel_q ? wr_addr : ADDR_W'(dst_s1);
		wdata_a = sel_q ? rot_src : wr_data;
		wdata_b = sel_q ? wr_data : rot_src;
	end

	// Response word for ops answered without the rotate sequence
	always_comb begin
		rsp_d.top_word = (fill_d == '0) ? 32'd0 : 32'(tos_d);
		rsp_d.count    = 5'(fill_d);
		rsp_d.status   = status_d;
	end

	wss_bank u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata_a),
		.raddr (rd_addr),
		.rdata (rd_a)
	);

	wss_bank u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (wdata_b),
		.raddr (rd_addr),
		.rdata (rd_b)
	);

	wss_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rot_go),
		.amount  (req.amount),
		.divisor (fill_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Control, rotate sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			sel_q     <= 1'b0;
			fwd_q     <= 1'b0;
			v_s1      <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			fill_q <= fill_d;
			fwd_q  <= wr_act && (wr_addr == rd_addr);
			v_s1   <= (state_q == S_COPY);
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (accept && !rot_go) begin
				rsp_valid <= 1'b1;
				rsp       <= rsp_d;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rot_go) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						src_q   <= mod_rem;
						idx_q   <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					dst_s1     <= idx_q;
					src_tos_s1 <= (src_q == last_idx);
					src_q      <= (src_q == last_idx) ? '0 : src_q + 1'b1;
					idx_q      <= idx_q + 1'b1;
					if (idx_q == last_idx) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q        <= S_IDLE;
					sel_q          <= !sel_q;
					rsp_valid      <= 1'b1;
					rsp.top_word   <= 32'(rot_src);
					rsp.count      <= 5'(fill_q);
					rsp.status     <= ST_OK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Top register and forwarding data
	always_ff @(posedge clk) begin
		tos_q      <= tos_d;
		fwd_data_q <= wr_data;
	end

endmodule

// File: rtl/core/wss_bank.sv
module wss_bank (
	input  logic          clk,
	input  logic          we,
	input  wss_pkg::addr_t waddr,
	input  wss_pkg::word_t wdata,
	input  wss_pkg::addr_t raddr,
	output wss_pkg::word_t rdata
);
	import wss_pkg::*;

	word_t mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/wss_mod.sv
module wss_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wss_pkg::AMT_W-1:0] amount,
	input  wss_pkg::cnt_t             divisor,
	output logic                      done,
	output wss_pkg::cnt_t             rem
);
	import wss_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] bit_q;
	logic [AMT_W-1:0] amt_q;
	cnt_t             div_q;
	cnt_t             rem_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	cnt_t           rem_next;

	// Restoring remainder step: bring in the next dividend bit
	always_comb begin
		trial    = {rem_q, amt_q[AMT_W-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = (trial >= {1'b0, div_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (busy_q) begin
			bit_q <= bit_q + 1'b1;
			if (bit_q == BIT_W'(AMT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			amt_q <= amount;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			amt_q <= amt_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/wss_check.sv
module wss_check (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input wss_pkg::rsp_t rsp
);
	import wss_pkg::*;

	// Full is only reported with the stack at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == 5'(DEPTH))
		else $error("full status with count below depth");

	// Empty status leaves an empty stack with a zero top word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.count == 5'd0) && (rsp.top_word == 32'd0))
		else $error("empty status with entries held");

	// Swap refusal only with fewer than two entries
	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FEW) |-> rsp.count < 5'd2)
		else $error("few status with two or more entries");

	// Empty stack reads as zero
	a_zero_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.count == 5'd0) |-> rsp.top_word == 32'd0)
		else $error("nonzero top word on empty stack");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

endmodule

bind word_stack_with_dup_swap_rotate wss_check u_wss_check (.*);
